### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

### rtl/core/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// types, constants and character classification for the hex token parser
// ----------------------------------------------------------------------------
package htb_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned LenW        = 3;
  localparam int unsigned StoredChars = 4;

  localparam logic [LenW-1:0]  LenSat      = 3'd5;
  localparam logic [LenW-1:0]  LenShort    = 3'd2;
  localparam logic [LenW-1:0]  LenPrefixed = 3'd4;
  localparam logic [LenW-1:0]  LenStored   = 3'd4;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChNine      = 8'h39;
  localparam logic [CharW-1:0] ChLowA      = 8'h61;
  localparam logic [CharW-1:0] ChLowF      = 8'h66;
  localparam logic [CharW-1:0] ChUpA       = 8'h41;
  localparam logic [CharW-1:0] ChUpF       = 8'h46;
  localparam logic [CharW-1:0] ChLowX      = 8'h78;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChCr        = 8'h0d;
  localparam logic [3:0]       LetterBias  = 4'd9;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             end_of_text;
  } item_t;

  typedef logic [StoredChars-1:0][CharW-1:0] chars_t;

  typedef struct packed {
    logic             ok;
    logic [CharW-1:0] value;
  } decode_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return ((c >= ChZero) && (c <= ChNine)) || ((c >= ChLowA) && (c <= ChLowF)) ||
           ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  // letters a-f and A-F share the low nibble pattern 1..6
  function automatic logic [3:0] hex_val(input logic [CharW-1:0] c);
    if (c <= ChNine) begin
      return c[3:0];
    end else begin
      return c[3:0] + LetterBias;
    end
  endfunction

  function automatic decode_t decode_word(input logic [LenW-1:0] len, input chars_t chars);
    decode_t          r;
    logic [CharW-1:0] hi;
    logic [CharW-1:0] lo;
    r  = '0;
    hi = chars[0];
    lo = chars[1];
    if (len == LenShort) begin
      r.ok = is_hex(chars[0]) && is_hex(chars[1]);
    end else if (len == LenPrefixed) begin
      hi   = chars[2];
      lo   = chars[3];
      r.ok = (chars[0] == ChZero) && (chars[1] == ChLowX) && is_hex(chars[2]) &&
             is_hex(chars[3]);
    end
    r.value = {hex_val(hi), hex_val(lo)};
    return r;
  endfunction

endpackage

### rtl/core/hex_token_to_byte_parser.sv
// ----------------------------------------------------------------------------
// hex_token_to_byte_parser
// turns whitespace separated hex words of a text stream into bytes
// ----------------------------------------------------------------------------
// input channel: one text character per beat on text_char_i, with
// end_of_text_i marking the last character of a text. output channel: one
// byte_value_o beat for each word of the form "hh" or "0xhh" (h a hex digit);
// every other word gives no beat. words end at tab, line feed, vertical tab,
// form feed, carriage return, space, or at the end-of-text character.
// both channels use valid/stall; a beat moves when valid is high and stall
// is low.
// path: a taken character waits in the input register, the word unit decodes
// it from there, and the byte of a finished word is captured in the output
// register with out_valid_o; a stalled output beat holds that capture back.
// throughput: one character per cycle unless an output beat is stalled,
// set by the input and output stage registers around the word logic.
// when the receiver stalls, the output byte holds, the input register keeps
// its character, and in_stall_o rises once that register is full.
// reset clears the word in progress and both valid flags; the block is
// ready for a character as soon as reset is released.
// ----------------------------------------------------------------------------
module hex_token_to_byte_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [htb_pkg::CharW-1:0] text_char_i,
  input  logic                      end_of_text_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [htb_pkg::CharW-1:0] byte_value_o
);

  htb_pkg::item_t item_in;
  htb_pkg::item_t item;
  logic           item_valid;
  logic           take;

  assign item_in.text_char   = text_char_i;
  assign item_in.end_of_text = end_of_text_i;

  htb_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_in_i    (item_in),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  htb_word_unit u_word_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_value_o (byte_value_o)
  );

endmodule

### rtl/core/htb_in_stage.sv
// ----------------------------------------------------------------------------
// htb_in_stage
// input register: holds one character beat until the word unit takes it
// ----------------------------------------------------------------------------
module htb_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  htb_pkg::item_t item_in_i,
  input  logic          take_i,
  output logic          item_valid_o,
  output htb_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  htb_pkg::item_t item_q;
  logic           accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_in_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/core/htb_word_unit.sv
// ----------------------------------------------------------------------------
// htb_word_unit
// word state, hex decode and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module htb_word_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  htb_pkg::item_t              item_i,
  output logic                        take_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [htb_pkg::CharW-1:0]   byte_value_o
);

  logic [htb_pkg::LenW-1:0]  len_q, len_d, len_n;
  htb_pkg::chars_t           chars_q, chars_d, chars_n;
  logic                      out_valid_q, out_valid_d;
  logic [htb_pkg::CharW-1:0] byte_q;
  htb_pkg::decode_t          dec;
  logic                      space;
  logic                      finish;
  logic                      take;

  assign take  = item_valid_i && (!out_valid_q || !out_stall_i);
  assign space = htb_pkg::is_space(item_i.text_char);

  // word after this character
  always_comb begin
    len_n   = len_q;
    chars_n = chars_q;
    if (!space) begin
      if (len_q < htb_pkg::LenStored) begin
        chars_n[len_q[1:0]] = item_i.text_char;
      end
      if (len_q < htb_pkg::LenSat) begin
        len_n = len_q + 3'd1;
      end
    end
  end

  assign finish = space || item_i.end_of_text;
  assign dec    = htb_pkg::decode_word(len_n, chars_n);

  always_comb begin
    len_d   = len_q;
    chars_d = chars_q;
    if (take) begin
      len_d   = finish ? '0 : len_n;
      chars_d = item_i.end_of_text ? '0 : chars_n;
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = finish && dec.ok;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      chars_q     <= chars_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= dec.value;
    end
  end

  assign take_o       = take;
  assign out_valid_o  = out_valid_q;
  assign byte_value_o = byte_q;

  `ASSERT_NEVER(a_len_range, len_q > htb_pkg::LenSat)
  `ASSERT_CLK(a_eot_clears, take && item_i.end_of_text |=> len_q == '0 && chars_q == '0)
  `ASSERT_CLK(a_no_spurious_beat, !take |=> !out_valid_q || $past(out_valid_q))
  `ASSERT_NEVER(a_take_blocked, take && out_valid_q && out_stall_i)

endmodule
